[rtl/bls_pkg.sv]
// Shared types and constants for the breathing LED status PWM block.
// Holds the microcode word layout, step addresses, register indexes and
// state class codes. No dependencies.
package bls_pkg;

  localparam int unsigned SwW     = 26;
  localparam int unsigned PerW    = 16;
  localparam int unsigned StpW    = 10;
  localparam int unsigned ElW     = 16;
  localparam int unsigned ClsW    = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 26;
  localparam int unsigned PcW     = 4;
  localparam int unsigned DivCntW = 5;

  localparam logic [DivCntW-1:0] DivSteps = DivCntW'(SwW);

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_SLOW_PERIOD  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SLOW_STEPS   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_FAST_PERIOD  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_FAST_STEPS   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_WRAP_LIMIT   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_IDLE_TIMEOUT = 3'd5;

  // register reset values
  localparam logic [PerW-1:0] RST_SLOW_PERIOD  = 16'd5000;
  localparam logic [StpW-1:0] RST_SLOW_STEPS   = 10'd100;
  localparam logic [PerW-1:0] RST_FAST_PERIOD  = 16'd2500;
  localparam logic [StpW-1:0] RST_FAST_STEPS   = 10'd50;
  localparam logic [SwW-1:0]  RST_WRAP_LIMIT   = 26'd50000000;
  localparam logic [SwW-1:0]  RST_IDLE_TIMEOUT = 26'd6000000;

  // state classes; codes above error behave as error
  localparam logic [ClsW-1:0] CLS_DFU         = 3'd0;
  localparam logic [ClsW-1:0] CLS_UPLOAD      = 3'd1;
  localparam logic [ClsW-1:0] CLS_DOWNLOAD    = 3'd2;
  localparam logic [ClsW-1:0] CLS_LOADER_IDLE = 3'd3;
  localparam logic [ClsW-1:0] CLS_ERROR       = 3'd4;

  // step addresses used as jump targets
  localparam logic [PcW-1:0] PC_IDLE   = 4'd0;
  localparam logic [PcW-1:0] PC_DIV_TP = 4'd2;
  localparam logic [PcW-1:0] PC_FINISH = 4'd10;

  typedef enum logic [3:0] {
    OP_NOP        = 4'd0,
    OP_IDLE       = 4'd1,
    OP_SEL_MAIN   = 4'd2,
    OP_DIV_TP     = 4'd3,
    OP_CAP_TP     = 4'd4,
    OP_DIV_QS     = 4'd5,
    OP_CAP_QS     = 4'd6,
    OP_MUL        = 4'd7,
    OP_DIV_DS     = 4'd8,
    OP_CAP_DS     = 4'd9,
    OP_SEL_SECOND = 4'd10,
    OP_FINISH     = 4'd11
  } op_e;

  typedef enum logic [2:0] {
    C_NEXT     = 3'd0,
    C_WAIT_IN  = 3'd1,
    C_WAIT_DIV = 3'd2,
    C_WAIT_OUT = 3'd3,
    C_JMP_CONST = 3'd4,
    C_JMP_LOOP = 3'd5,
    C_JUMP     = 3'd6
  } cond_e;

  typedef struct packed {
    op_e            op;
    cond_e          cond;
    logic [PcW-1:0] target;
  } ucode_t;

  // status flags the sequencer branches on
  typedef struct packed {
    logic in_valid;
    logic div_busy;
    logic out_free;
    logic main_const;
    logic second_loop;
  } seq_cond_t;

  // current step as seen by the datapath
  typedef struct packed {
    op_e  op;
    logic fire;
  } uop_t;

endpackage

[rtl/breathing_led_status_pwm.sv]
// Top level of the breathing LED status PWM block: datapath, config
// registers and output register. Uses bls_pkg, bls_seq and bls_div.
//
//  channel | direction | signals                                   | transfer when
//  --------+-----------+-------------------------------------------+------------------------
//  in      | sink      | in_valid_i/in_ready_o, elapsed_us_i,      | in_valid_i & in_ready_o
//          |           | state_class_i                             |
//  out     | source    | out_valid_o/out_ready_i, led_main_on_o,   | out_valid_o & out_ready_i
//          |           | led_second_on_o, jump_request_o           |
//  cfg     | sink      | cfg_valid_i/cfg_ready_o, cfg_index_i,     | cfg_valid_i & cfg_ready_o
//          |           | cfg_data_i                                |
//
// One tick at a time. A breathing channel costs three divisions on the shared
// 26-step restoring divider plus a multiply. A tick works one breathing channel,
// two when uploading, and none in loader idle, where the main channel is held
// on.
// Reset clears the stopwatch, restores the register defaults and empties the
// output register. A stalled result sits in the output register; the next
// tick is accepted and worked on meanwhile, and only the final step holds.
module breathing_led_status_pwm (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [bls_pkg::ElW-1:0]     elapsed_us_i,
  input  logic [bls_pkg::ClsW-1:0]    state_class_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       led_main_on_o,
  output logic                       led_second_on_o,
  output logic                       jump_request_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [bls_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [bls_pkg::CfgW-1:0]    cfg_data_i
);
  import bls_pkg::*;

  // configuration
  logic [PerW-1:0] slow_per_q, fast_per_q;
  logic [StpW-1:0] slow_stp_q, fast_stp_q;
  logic [SwW-1:0]  wrap_q, tmo_q;

  // datapath
  logic [SwW-1:0]  sw_q;
  logic [ClsW-1:0] cls_q;
  logic [PerW-1:0] per_q, r1_q;
  logic [StpW-1:0] stp_q, step_q;
  logic [SwW-1:0]  q1_q, prod_q;
  logic            odd_q, chan_q, main_q, second_q;

  // output register
  logic out_valid_q, main_out_q, second_out_q, jump_out_q;

  seq_cond_t       cond;
  uop_t            uop;
  logic            div_start, div_busy;
  logic [SwW-1:0]  div_dividend, div_quot;
  logic [PerW-1:0] div_divisor, div_rem;

  logic [PerW-1:0] slow_per_nz, fast_per_nz, duty, duty_eff;
  logic [StpW-1:0] slow_stp_nz, fast_stp_nz;
  logic [SwW-1:0]  sw_wrapped;
  logic            is_const, is_err, out_free;

  // a period or step count written as zero acts as one
  assign slow_per_nz = (slow_per_q == '0) ? PerW'(1) : slow_per_q;
  assign fast_per_nz = (fast_per_q == '0) ? PerW'(1) : fast_per_q;
  assign slow_stp_nz = (slow_stp_q == '0) ? StpW'(1) : slow_stp_q;
  assign fast_stp_nz = (fast_stp_q == '0) ? StpW'(1) : fast_stp_q;

  assign is_const = (cls_q == CLS_LOADER_IDLE);
  assign is_err   = (cls_q >= CLS_ERROR);
  assign out_free = !out_valid_q || out_ready_i;

  assign cond = '{in_valid:    in_valid_i,
                  div_busy:    div_busy,
                  out_free:    out_free,
                  main_const:  is_const,
                  second_loop: !chan_q && (cls_q == CLS_UPLOAD)};

  bls_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cond_i (cond),
    .uop_o  (uop)
  );

  // pick divider operands by step
  always_comb begin
    div_start    = 1'b0;
    div_dividend = sw_q;
    div_divisor  = per_q;
    case (uop.op)
      OP_DIV_TP: begin
        div_start = 1'b1;
      end
      OP_DIV_QS: begin
        div_start    = 1'b1;
        div_dividend = q1_q;
        div_divisor  = PerW'(stp_q);
      end
      OP_DIV_DS: begin
        div_start    = 1'b1;
        div_dividend = prod_q;
        div_divisor  = PerW'(stp_q);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  bls_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // duty stays below the period; reverse it on odd sweeps
  assign duty       = div_quot[PerW-1:0];
  assign duty_eff   = odd_q ? (per_q - duty) : duty;
  assign sw_wrapped = (sw_q > wrap_q) ? '0 : sw_q;

  // configuration registers, always ready; unused indexes drop the write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_per_q <= RST_SLOW_PERIOD;
      slow_stp_q <= RST_SLOW_STEPS;
      fast_per_q <= RST_FAST_PERIOD;
      fast_stp_q <= RST_FAST_STEPS;
      wrap_q     <= RST_WRAP_LIMIT;
      tmo_q      <= RST_IDLE_TIMEOUT;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SLOW_PERIOD:  slow_per_q <= cfg_data_i[PerW-1:0];
        REG_SLOW_STEPS:   slow_stp_q <= cfg_data_i[StpW-1:0];
        REG_FAST_PERIOD:  fast_per_q <= cfg_data_i[PerW-1:0];
        REG_FAST_STEPS:   fast_stp_q <= cfg_data_i[StpW-1:0];
        REG_WRAP_LIMIT:   wrap_q     <= cfg_data_i[SwW-1:0];
        REG_IDLE_TIMEOUT: tmo_q      <= cfg_data_i[SwW-1:0];
        default: begin
        end
      endcase
    end
  end

  // stopwatch and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (uop.fire && uop.op == OP_IDLE) begin
        // wraps modulo 2^26
        sw_q <= sw_q + SwW'(elapsed_us_i);
      end else if (uop.fire && uop.op == OP_FINISH) begin
        sw_q <= sw_wrapped;
      end
      if (uop.fire && uop.op == OP_FINISH) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // per-tick working registers
  always_ff @(posedge clk_i) begin
    if (uop.fire) begin
      case (uop.op)
        OP_IDLE: begin
          cls_q  <= state_class_i;
          chan_q <= 1'b0;
        end
        OP_SEL_MAIN: begin
          if (is_const) begin
            main_q   <= 1'b1;
            second_q <= 1'b0;
          end else if (cls_q == CLS_DOWNLOAD) begin
            per_q <= fast_per_nz;
            stp_q <= fast_stp_nz;
          end else begin
            per_q <= slow_per_nz;
            stp_q <= slow_stp_nz;
          end
        end
        OP_CAP_TP: begin
          r1_q <= div_rem;
          q1_q <= div_quot;
        end
        OP_CAP_QS: begin
          step_q <= div_rem[StpW-1:0];
          odd_q  <= div_quot[0];
        end
        OP_MUL: begin
          prod_q <= SwW'(per_q) * SwW'(step_q);
        end
        OP_CAP_DS: begin
          if (chan_q) begin
            second_q <= (r1_q > duty_eff);
          end else begin
            main_q <= (r1_q > duty_eff);
          end
        end
        OP_SEL_SECOND: begin
          // advance to the fast channel once, otherwise settle the second level
          if (!chan_q) begin
            if (cls_q == CLS_UPLOAD) begin
              per_q  <= fast_per_nz;
              stp_q  <= fast_stp_nz;
              chan_q <= 1'b1;
            end else begin
              second_q <= is_err ? main_q : 1'b0;
            end
          end
        end
        OP_FINISH: begin
          main_out_q   <= main_q;
          second_out_q <= second_q;
          jump_out_q   <= (sw_wrapped > tmo_q) && is_const;
        end
        default: begin
        end
      endcase
    end
  end

  assign in_ready_o      = (uop.op == OP_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign out_valid_o     = out_valid_q;
  assign led_main_on_o   = main_out_q;
  assign led_second_on_o = second_out_q;
  assign jump_request_o  = jump_out_q;

endmodule

[rtl/bls_div.sv]
// Restoring divider, one quotient bit per cycle, for the breathing PWM block.
// 26-bit dividend, 16-bit divisor. Depends on bls_pkg.
module bls_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [bls_pkg::SwW-1:0]  dividend_i,
  input  logic [bls_pkg::PerW-1:0] divisor_i,
  output logic                    busy_o,
  output logic [bls_pkg::SwW-1:0]  quot_o,
  output logic [bls_pkg::PerW-1:0] rem_o
);
  import bls_pkg::*;

  logic               busy_q, busy_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [SwW-1:0]     quo_q, quo_d;
  logic [PerW-1:0]    rem_q, rem_d;
  logic [PerW-1:0]    dvs_q, dvs_d;
  logic [PerW:0]      trial;
  logic               fits;

  assign trial = {rem_q, quo_q[SwW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DivSteps;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[SwW-2:0], fits};
      rem_d = fits ? PerW'(trial - {1'b0, dvs_q}) : trial[PerW-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

[rtl/bls_seq.sv]
// Microcode sequencer: step counter, control store and branch logic.
// Depends on bls_pkg for the control word and condition types.
module bls_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bls_pkg::seq_cond_t cond_i,
  output bls_pkg::uop_t      uop_o
);
  import bls_pkg::*;

  logic [PcW-1:0] pc_q, pc_d;
  ucode_t         uw;
  logic           fire;
  logic [PcW-1:0] pc_inc;

  function automatic ucode_t rom(input logic [PcW-1:0] pc);
    ucode_t w;
    case (pc)
      4'd0:    w = '{op: OP_IDLE,       cond: C_WAIT_IN,   target: PC_IDLE};
      4'd1:    w = '{op: OP_SEL_MAIN,   cond: C_JMP_CONST, target: PC_FINISH};
      4'd2:    w = '{op: OP_DIV_TP,     cond: C_NEXT,      target: PC_IDLE};
      4'd3:    w = '{op: OP_CAP_TP,     cond: C_WAIT_DIV,  target: PC_IDLE};
      4'd4:    w = '{op: OP_DIV_QS,     cond: C_NEXT,      target: PC_IDLE};
      4'd5:    w = '{op: OP_CAP_QS,     cond: C_WAIT_DIV,  target: PC_IDLE};
      4'd6:    w = '{op: OP_MUL,        cond: C_NEXT,      target: PC_IDLE};
      4'd7:    w = '{op: OP_DIV_DS,     cond: C_NEXT,      target: PC_IDLE};
      4'd8:    w = '{op: OP_CAP_DS,     cond: C_WAIT_DIV,  target: PC_IDLE};
      4'd9:    w = '{op: OP_SEL_SECOND, cond: C_JMP_LOOP,  target: PC_DIV_TP};
      4'd10:   w = '{op: OP_FINISH,     cond: C_WAIT_OUT,  target: PC_IDLE};
      default: w = '{op: OP_NOP,        cond: C_JUMP,      target: PC_IDLE};
    endcase
    return w;
  endfunction

  assign uw     = rom(pc_q);
  assign pc_inc = pc_q + 1'b1;

  always_comb begin
    fire = 1'b1;
    pc_d = pc_inc;
    case (uw.cond)
      C_NEXT: begin
        pc_d = pc_inc;
      end
      C_WAIT_IN: begin
        fire = cond_i.in_valid;
        pc_d = fire ? pc_inc : pc_q;
      end
      C_WAIT_DIV: begin
        fire = !cond_i.div_busy;
        pc_d = fire ? pc_inc : pc_q;
      end
      C_WAIT_OUT: begin
        fire = cond_i.out_free;
        pc_d = fire ? uw.target : pc_q;
      end
      C_JMP_CONST: begin
        pc_d = cond_i.main_const ? uw.target : pc_inc;
      end
      C_JMP_LOOP: begin
        pc_d = cond_i.second_loop ? uw.target : pc_inc;
      end
      C_JUMP: begin
        pc_d = uw.target;
      end
      default: begin
        pc_d = PC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign uop_o = '{op: uw.op, fire: fire};

endmodule
